FILE: sv/fntw_pkg.sv
package fntw_pkg;

	// Item kinds
	localparam logic [1:0] KIND_DRAW  = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// Cursor registers hold any loaded value and any on-screen position
	localparam int COL_W = 8;
	localparam int ROW_W = 8;

	// Glyph geometry and cursor motion
	localparam int         GLYPH_COLS  = 5;
	localparam int         GLYPH_COUNT = 96;
	localparam int         GIDX_W      = 7;
	localparam logic [6:0] FIRST_CODE  = 7'd32;
	localparam int         ADVANCE_X   = 6;
	localparam int         ADVANCE_Y   = 8;

	// One access per glyph column and page: five columns, two pages
	localparam int STEP_W     = 4;
	localparam int DRAW_STEPS = 2 * GLYPH_COLS;

	// Controller to datapath commands
	typedef struct packed {
		logic latch;        // capture item fields
		logic load_cursor;  // load cursor from start position
		logic zero_data;    // result byte is zero
		logic draw_step;    // issue one glyph column/page access
		logic advance;      // move cursor after a glyph
		logic home;         // cursor to 0,0
		logic clr_step;     // zero one framebuffer byte
		logic rd_issue;     // read the addressed byte
		logic rd_take;      // capture the read byte
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic step_last;
		logic clr_last;
	} sts_t;

	// 5x7 font, codes 32 to 127, one byte per column, bit n is row n
	localparam logic [7:0] FONT_ROM [GLYPH_COUNT][GLYPH_COLS] = '{
		'{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5f,8'h00,8'h00},
		'{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7f,8'h14,8'h7f,8'h14},
		'{8'h24,8'h2a,8'h7f,8'h2a,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
		'{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
		'{8'h00,8'h1c,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1c,8'h00},
		'{8'h14,8'h08,8'h3e,8'h08,8'h14}, '{8'h08,8'h08,8'h3e,8'h08,8'h08},
		'{8'h00,8'h50,8'h30,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
		'{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
		'{8'h3e,8'h51,8'h49,8'h45,8'h3e}, '{8'h00,8'h42,8'h7f,8'h40,8'h00},
		'{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4b,8'h31},
		'{8'h18,8'h14,8'h12,8'h7f,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
		'{8'h3c,8'h4a,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
		'{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1e},
		'{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
		'{8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
		'{8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
		'{8'h32,8'h49,8'h79,8'h41,8'h3e}, '{8'h7e,8'h11,8'h11,8'h11,8'h7e},
		'{8'h7f,8'h49,8'h49,8'h49,8'h36}, '{8'h3e,8'h41,8'h41,8'h41,8'h22},
		'{8'h7f,8'h41,8'h41,8'h22,8'h1c}, '{8'h7f,8'h49,8'h49,8'h49,8'h41},
		'{8'h7f,8'h09,8'h09,8'h09,8'h01}, '{8'h3e,8'h41,8'h49,8'h49,8'h7a},
		'{8'h7f,8'h08,8'h08,8'h08,8'h7f}, '{8'h00,8'h41,8'h7f,8'h41,8'h00},
		'{8'h20,8'h40,8'h41,8'h3f,8'h01}, '{8'h7f,8'h08,8'h14,8'h22,8'h41},
		'{8'h7f,8'h40,8'h40,8'h40,8'h40}, '{8'h7f,8'h02,8'h0c,8'h02,8'h7f},
		'{8'h7f,8'h04,8'h08,8'h10,8'h7f}, '{8'h3e,8'h41,8'h41,8'h41,8'h3e},
		'{8'h7f,8'h09,8'h09,8'h09,8'h06}, '{8'h3e,8'h41,8'h51,8'h21,8'h5e},
		'{8'h7f,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
		'{8'h01,8'h01,8'h7f,8'h01,8'h01}, '{8'h3f,8'h40,8'h40,8'h40,8'h3f},
		'{8'h1f,8'h20,8'h40,8'h20,8'h1f}, '{8'h3f,8'h40,8'h38,8'h40,8'h3f},
		'{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h07,8'h08,8'h70,8'h08,8'h07},
		'{8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h7f,8'h41,8'h41,8'h00},
		'{8'h02,8'h04,8'h08,8'h10,8'h20}, '{8'h00,8'h41,8'h41,8'h7f,8'h00},
		'{8'h04,8'h02,8'h01,8'h02,8'h04}, '{8'h40,8'h40,8'h40,8'h40,8'h40},
		'{8'h00,8'h01,8'h02,8'h04,8'h00}, '{8'h20,8'h54,8'h54,8'h54,8'h78},
		'{8'h7f,8'h48,8'h44,8'h44,8'h38}, '{8'h38,8'h44,8'h44,8'h44,8'h20},
		'{8'h38,8'h44,8'h44,8'h48,8'h7f}, '{8'h38,8'h54,8'h54,8'h54,8'h18},
		'{8'h08,8'h7e,8'h09,8'h01,8'h02}, '{8'h0c,8'h52,8'h52,8'h52,8'h3e},
		'{8'h7f,8'h08,8'h04,8'h04,8'h78}, '{8'h00,8'h44,8'h7d,8'h40,8'h00},
		'{8'h20,8'h40,8'h44,8'h3d,8'h00}, '{8'h7f,8'h10,8'h28,8'h44,8'h00},
		'{8'h00,8'h41,8'h7f,8'h40,8'h00}, '{8'h7c,8'h04,8'h18,8'h04,8'h78},
		'{8'h7c,8'h08,8'h04,8'h04,8'h78}, '{8'h38,8'h44,8'h44,8'h44,8'h38},
		'{8'h7c,8'h14,8'h14,8'h14,8'h08}, '{8'h08,8'h14,8'h14,8'h18,8'h7c},
		'{8'h7c,8'h08,8'h04,8'h04,8'h08}, '{8'h48,8'h54,8'h54,8'h54,8'h20},
		'{8'h04,8'h3f,8'h44,8'h40,8'h20}, '{8'h3c,8'h40,8'h40,8'h20,8'h7c},
		'{8'h1c,8'h20,8'h40,8'h20,8'h1c}, '{8'h3c,8'h40,8'h30,8'h40,8'h3c},
		'{8'h44,8'h28,8'h10,8'h28,8'h44}, '{8'h0c,8'h50,8'h50,8'h50,8'h3c},
		'{8'h44,8'h64,8'h54,8'h4c,8'h44}, '{8'h00,8'h08,8'h36,8'h41,8'h00},
		'{8'h00,8'h00,8'h7f,8'h00,8'h00}, '{8'h00,8'h41,8'h36,8'h08,8'h00},
		'{8'h10,8'h08,8'h08,8'h10,8'h08}, '{8'h00,8'h00,8'h00,8'h00,8'h00}
	};

endpackage

FILE: sv/fntw_ram.sv
module fntw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 504
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/fntw_dp.sv
module fntw_dp #(
	parameter int SCREEN_WIDTH  = 84,
	parameter int SCREEN_HEIGHT = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  fntw_pkg::cmd_t cmd,
	input  logic [6:0]    start_x,
	input  logic [5:0]    start_y,
	input  logic [6:0]    char_code,
	input  logic [8:0]    read_address,
	output fntw_pkg::sts_t sts,
	output logic [7:0]    read_data,
	output logic [6:0]    cursor_col,
	output logic [5:0]    cursor_row
);

	import fntw_pkg::*;

	localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
	localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int LAST_BITS   = SCREEN_HEIGHT - 8 * (PAGE_COUNT - 1);
	localparam logic [7:0] LAST_MASK = 8'((16'd1 << LAST_BITS) - 16'd1);

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [GIDX_W-1:0] gidx_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic              rd_ok_q;
	logic [STEP_W-1:0] step_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              wr_en_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic [7:0]        wr_mask_s1;
	logic [7:0]        wr_val_s1;
	logic [7:0]        read_data_q;

	logic [2:0]        glyph_col;
	logic              page_hi;
	logic [8:0]        px;
	logic [5:0]        page;
	logic [7:0]        glyph_bits;
	logic [15:0]       shifted;
	logic [15:0]       smask;
	logic [7:0]        pmask;
	logic [7:0]        pval;
	logic [7:0]        hmask;
	logic              in_screen;
	logic [ADDR_W-1:0] draw_addr;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;
	logic [7:0]        merged;

	logic [8:0]        col_sum;
	logic              col_wrap;
	logic [8:0]        row_sum;
	logic              wrap_home;
	logic [COL_W-1:0]  col_next;
	logic [ROW_W-1:0]  row_next;

	// Decode the current access: glyph column and page within the text line
	always_comb begin
		glyph_col  = step_q[3:1];
		page_hi    = step_q[0];
		px         = {1'b0, col_q} + 9'(glyph_col);
		page       = {1'b0, row_q[7:3]} + 6'(page_hi);
		glyph_bits = FONT_ROM[gidx_q][glyph_col];
		shifted    = {9'b0, glyph_bits[6:0]} << row_q[2:0];
		smask      = 16'h007f << row_q[2:0];
		pmask      = page_hi ? smask[15:8] : smask[7:0];
		pval       = page_hi ? shifted[15:8] : shifted[7:0];
		hmask      = (page == 6'(PAGE_COUNT - 1)) ? LAST_MASK : 8'hff;
		in_screen  = (px < 9'(SCREEN_WIDTH)) && (page < 6'(PAGE_COUNT));
		draw_addr  = ADDR_W'(32'(page) * SCREEN_WIDTH + 32'(px));
	end

	// Merge glyph bits into the byte read in the previous cycle
	assign merged = (ram_rdata & ~wr_mask_s1) | (wr_val_s1 & wr_mask_s1);

	// Share the memory ports between drawing, clearing and reading
	always_comb begin
		ram_we    = wr_en_s1 | cmd.clr_step;
		ram_waddr = cmd.clr_step ? clr_addr_q : wr_addr_s1;
		ram_wdata = cmd.clr_step ? 8'h00 : merged;
		ram_re    = (cmd.draw_step & in_screen) | (cmd.rd_issue & rd_ok_q);
		ram_raddr = cmd.rd_issue ? rd_addr_q : draw_addr;
	end

	fntw_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_frame (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Cursor advance with line and screen wrap
	always_comb begin
		col_sum   = {1'b0, col_q} + 9'(ADVANCE_X);
		col_wrap  = col_sum >= 9'(SCREEN_WIDTH);
		row_sum   = col_wrap ? ({1'b0, row_q} + 9'(ADVANCE_Y)) : {1'b0, row_q};
		wrap_home = row_sum >= 9'(SCREEN_HEIGHT);
		col_next  = (col_wrap || wrap_home) ? '0 : col_sum[COL_W-1:0];
		row_next  = wrap_home ? '0 : row_sum[ROW_W-1:0];
	end

	// Cursor, step and sweep counters, write stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			step_q     <= '0;
			clr_addr_q <= '0;
			wr_en_s1   <= 1'b0;
		end else begin
			if (cmd.load_cursor) begin
				col_q <= {1'b0, start_x};
				row_q <= {2'b0, start_y};
			end else if (cmd.home) begin
				col_q <= '0;
				row_q <= '0;
			end else if (cmd.advance) begin
				col_q <= col_next;
				row_q <= row_next;
			end
			if (cmd.draw_step) begin
				step_q <= sts.step_last ? '0 : step_q + 1'b1;
			end
			if (cmd.clr_step) begin
				clr_addr_q <= sts.clr_last ? '0 : clr_addr_q + 1'b1;
			end
			wr_en_s1 <= cmd.draw_step & in_screen;
		end
	end

	// Item fields, write stage payload and result byte
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			gidx_q    <= (char_code >= FIRST_CODE) ? (char_code - FIRST_CODE) : '0;
			rd_addr_q <= ADDR_W'(32'(read_address));
			rd_ok_q   <= 32'(read_address) < STORE_BYTES;
		end
		wr_addr_s1 <= draw_addr;
		wr_mask_s1 <= pmask & hmask;
		wr_val_s1  <= pval;
		if (cmd.zero_data) begin
			read_data_q <= 8'h00;
		end else if (cmd.rd_take) begin
			read_data_q <= rd_ok_q ? ram_rdata : 8'h00;
		end
	end

	assign sts.step_last = step_q == STEP_W'(DRAW_STEPS - 1);
	assign sts.clr_last  = clr_addr_q == ADDR_W'(STORE_BYTES - 1);

	assign read_data  = read_data_q;
	assign cursor_col = col_q[6:0];
	assign cursor_row = row_q[5:0];

	// A read-modify-write never reads the byte it is writing back
	a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en_s1 && ram_re && cmd.draw_step) |-> (ram_raddr != wr_addr_s1))
		else $error("draw read collides with pending write");

	// After an advance the cursor is on screen
	a_advance_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |=> (({1'b0, col_q} < 9'(SCREEN_WIDTH))
			&& ({1'b0, row_q} < 9'(SCREEN_HEIGHT))))
		else $error("cursor off screen after advance");

	// Step counter stays within the glyph access sequence
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_W'(DRAW_STEPS - 1))
		else $error("draw step out of range");

endmodule

FILE: sv/fntw_ctrl.sv
module fntw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     kind,
	input  logic           start_text,
	input  fntw_pkg::sts_t sts,
	output fntw_pkg::cmd_t cmd,
	output logic           busy,
	output logic           done
);

	import fntw_pkg::*;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_DRAW,
		S_DRAIN,
		S_CLR,
		S_RD_ISSUE,
		S_RD_TAKE,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   busy_q;
	logic   done_q;
	logic   accept;

	assign accept = start && !busy_q;

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_INIT: begin
				if (sts.clr_last) state_next = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					unique case (kind)
						KIND_DRAW:  state_next = S_DRAW;
						KIND_CLEAR: state_next = S_CLR;
						KIND_READ:  state_next = S_RD_ISSUE;
						default:    state_next = S_DONE;
					endcase
				end
			end
			S_DRAW: begin
				if (sts.step_last) state_next = S_DRAIN;
			end
			S_DRAIN:    state_next = S_DONE;
			S_CLR: begin
				if (sts.clr_last) state_next = S_DONE;
			end
			S_RD_ISSUE: state_next = S_RD_TAKE;
			S_RD_TAKE:  state_next = S_DONE;
			S_DONE:     state_next = S_IDLE;
			default:    state_next = S_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd             = '0;
		cmd.latch       = accept;
		cmd.load_cursor = accept && (kind == KIND_DRAW) && start_text;
		cmd.home        = accept && (kind == KIND_CLEAR);
		cmd.zero_data   = accept && (kind != KIND_READ);
		cmd.draw_step   = state_q == S_DRAW;
		cmd.advance     = state_q == S_DRAIN;
		cmd.clr_step    = (state_q == S_INIT) || (state_q == S_CLR);
		cmd.rd_issue    = state_q == S_RD_ISSUE;
		cmd.rd_take     = state_q == S_RD_TAKE;
	end

	// Hold state and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			busy_q  <= state_next != S_IDLE;
			done_q  <= state_next == S_DONE;
		end
	end

	assign busy = busy_q;
	assign done = done_q;

	// The result strobe only shows while a transaction is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done without busy");

	// A result ends its transaction
	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("busy held after result");

	// Memory activities never overlap
	a_one_activity: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.draw_step, cmd.clr_step, cmd.rd_issue, cmd.rd_take, cmd.advance}))
		else $error("overlapping datapath commands");

	// An accepted transaction raises busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accept did not raise busy");

endmodule

FILE: sv/font_text_framebuffer_writer.sv
// Text renderer over a page-organized monochrome framebuffer (84x48 by
// default, one byte per eight vertical pixels) with a 5x7 font and a text
// cursor. A transaction is taken when start is high and busy is low; its
// single result appears for exactly one cycle with done high, and the
// receiver must take it then, since the block cannot hold it. A draw runs
// ten read-modify-write accesses (five glyph columns, two pages each)
// overlapped on the framebuffer's read and write ports, then a drain state
// that finishes the last write, then the done state. A read issues the
// framebuffer read, then takes the byte; an unused kind goes straight to
// done. A clear sweeps the framebuffer one byte a cycle over all
// SCREEN_WIDTH * ceil(SCREEN_HEIGHT / 8) bytes (504 by default). The same
// sweep runs after reset, and busy stays high until it completes.
module font_text_framebuffer_writer #(
	parameter int SCREEN_WIDTH  = 84,
	parameter int SCREEN_HEIGHT = 48
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	output logic       done,
	input  logic [1:0] kind,
	input  logic       start_text,
	input  logic [6:0] start_x,
	input  logic [5:0] start_y,
	input  logic [6:0] char_code,
	input  logic [8:0] read_address,
	output logic [7:0] read_data,
	output logic [6:0] cursor_col,
	output logic [5:0] cursor_row
);

	import fntw_pkg::*;

	cmd_t cmd;
	sts_t sts;

	fntw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.kind      (kind),
		.start_text(start_text),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	fntw_dp #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.start_x     (start_x),
		.start_y     (start_y),
		.char_code   (char_code),
		.read_address(read_address),
		.sts         (sts),
		.read_data   (read_data),
		.cursor_col  (cursor_col),
		.cursor_row  (cursor_row)
	);

endmodule
